// ===== rtl/core/bsd_pkg.sv =====
`default_nettype none

package bsd_pkg;

  // Longest frame, in decoded bytes, that is passed on.
  localparam int unsigned MAX_FRAME = 1024;

  // Width of the frame length field on the result port.
  localparam int unsigned LEN_W = 11;

  // Width of the internal byte counter, wide enough to hold MAX_FRAME itself.
  localparam int unsigned CNT_W = $clog2(MAX_FRAME + 1);

  // Framing symbols.
  localparam logic [7:0] SYM_START = 8'h00;
  localparam logic [7:0] SYM_END   = 8'h01;
  localparam logic [7:0] SYM_ESC   = 8'h02;

  // Escape codes and the bytes they stand for.
  localparam logic [7:0] ESC_CODE_START = 8'h30;
  localparam logic [7:0] ESC_CODE_END   = 8'h31;
  localparam logic [7:0] ESC_CODE_ESC   = 8'h32;
  localparam logic [7:0] ESC_CODE_FOUR  = 8'h34;
  localparam logic [7:0] ESC_BYTE_FOUR  = 8'h04;

  // One result item as it travels from the decoder to the output register.
  typedef struct packed {
    logic [7:0]       data;
    logic             frame_end;
    logic [LEN_W-1:0] len;
    logic             bad_escape;
    logic             overflowed;
  } res_t;

endpackage

`default_nettype wire

// ===== rtl/core/bsd_decode.sv =====
`default_nettype none

module bsd_decode
  import bsd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       consume,
  input  wire logic [7:0] byte_in,
  output logic            res_valid,
  output res_t            res
);

  logic             in_frame;
  logic             escape_pending;
  logic [CNT_W-1:0] byte_count;
  logic             bad_seen;
  logic             over_seen;

  logic             in_frame_next;
  logic             escape_pending_next;
  logic [CNT_W-1:0] byte_count_next;
  logic             bad_seen_next;
  logic             over_seen_next;

  logic             take_data;
  logic [7:0]       data_byte;

  // Frame decoding: one received byte updates the frame state and may
  // produce one data or end result.
  always_comb begin
    in_frame_next       = in_frame;
    escape_pending_next = escape_pending;
    byte_count_next     = byte_count;
    bad_seen_next       = bad_seen;
    over_seen_next      = over_seen;
    take_data           = 1'b0;
    data_byte           = byte_in;
    res_valid           = 1'b0;
    res.data            = 8'h00;
    res.frame_end       = 1'b0;

    if (byte_in == SYM_START) begin
      // A start symbol always opens a fresh frame.
      in_frame_next       = 1'b1;
      escape_pending_next = 1'b0;
      byte_count_next     = '0;
      bad_seen_next       = 1'b0;
      over_seen_next      = 1'b0;
    end else if (in_frame) begin
      if (byte_in == SYM_END) begin
        // A dangling escape before the end symbol counts as a bad escape.
        if (escape_pending) begin
          bad_seen_next = 1'b1;
        end
        res_valid           = 1'b1;
        res.frame_end       = 1'b1;
        in_frame_next       = 1'b0;
        escape_pending_next = 1'b0;
      end else if (escape_pending) begin
        escape_pending_next = 1'b0;
        case (byte_in)
          ESC_CODE_START: begin
            take_data = 1'b1;
            data_byte = SYM_START;
          end
          ESC_CODE_END: begin
            take_data = 1'b1;
            data_byte = SYM_END;
          end
          ESC_CODE_ESC: begin
            take_data = 1'b1;
            data_byte = SYM_ESC;
          end
          ESC_CODE_FOUR: begin
            take_data = 1'b1;
            data_byte = ESC_BYTE_FOUR;
          end
          default: begin
            bad_seen_next = 1'b1;
          end
        endcase
      end else if (byte_in == SYM_ESC) begin
        escape_pending_next = 1'b1;
      end else begin
        take_data = 1'b1;
      end

      // Decoded bytes beyond the frame limit are dropped and flagged.
      if (take_data) begin
        if (byte_count >= CNT_W'(MAX_FRAME)) begin
          over_seen_next = 1'b1;
        end else begin
          byte_count_next = byte_count + 1'b1;
          res_valid       = 1'b1;
          res.data        = data_byte;
        end
      end
    end

    res.len        = LEN_W'(byte_count_next);
    res.bad_escape = bad_seen_next;
    res.overflowed = over_seen_next;
  end

  // Frame state, updated only when a byte is taken from the input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame       <= 1'b0;
      escape_pending <= 1'b0;
      byte_count     <= '0;
      bad_seen       <= 1'b0;
      over_seen      <= 1'b0;
    end else if (consume) begin
      in_frame       <= in_frame_next;
      escape_pending <= escape_pending_next;
      byte_count     <= byte_count_next;
      bad_seen       <= bad_seen_next;
      over_seen      <= over_seen_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/bsd_out_buf.sv =====
`default_nettype none

module bsd_out_buf
  import bsd_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic load,
  input  wire logic res_valid,
  input  wire res_t res,
  input  wire logic stall,
  output logic      ready,
  output logic      valid,
  output res_t      data
);

  // The register can take a new result when it is empty or being drained.
  assign ready = !valid || !stall;

  // Valid flag of the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ready) begin
      valid <= load && res_valid;
    end
  end

  // Result payload; it holds while the downstream side stalls.
  always_ff @(posedge clk) begin
    if (ready && load && res_valid) begin
      data <= res;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/byte_stuffing_deframer.sv =====
`default_nettype none

// Path: input register, then the combinational decoder, then the output register.
// Throughput: one byte per cycle unless the output stalls, set by the single
// decode stage between the input register and the output register.
// Reset: rst is synchronous and active high; it closes any open frame, clears the
// length and flags, and empties both registers.
module byte_stuffing_deframer
  import bsd_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic [7:0]       in_byte,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic [7:0]            out_byte,
  output logic                  frame_end,
  output logic [LEN_W-1:0]      frame_len,
  output logic                  bad_escape,
  output logic                  overflowed
);

  logic       r_valid;
  logic [7:0] r_byte;
  logic       advance;
  logic       consume;
  logic       res_valid;
  res_t       res;
  res_t       out_res;

  // The held byte moves on whenever the output register can take a result.
  assign consume  = r_valid && advance;
  assign in_stall = r_valid && !advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      r_valid <= 1'b0;
    end else if (!in_stall) begin
      r_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      r_byte <= in_byte;
    end
  end

  bsd_decode u_decode (
    .clk       (clk),
    .rst       (rst),
    .consume   (consume),
    .byte_in   (r_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  bsd_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .load      (r_valid),
    .res_valid (res_valid),
    .res       (res),
    .stall     (out_stall),
    .ready     (advance),
    .valid     (out_valid),
    .data      (out_res)
  );

  assign out_byte   = out_res.data;
  assign frame_end  = out_res.frame_end;
  assign frame_len  = out_res.len;
  assign bad_escape = out_res.bad_escape;
  assign overflowed = out_res.overflowed;

  // An end result never carries a payload byte.
  a_end_no_data: assert property (@(posedge clk) disable iff (rst)
    (out_valid && frame_end) |-> (out_byte == 8'h00))
    else $error("end result carries a non-zero byte");

  // A data result always counts at least itself and never passes the limit.
  a_data_len: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !frame_end) |->
      ((frame_len != '0) && (frame_len <= LEN_W'(MAX_FRAME))))
    else $error("data result length out of range");

  // The input side stalls only while a byte waits in the input register.
  a_stall_held: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (r_valid && out_valid && out_stall))
    else $error("input stalled without a held byte");

  // A result that was stalled stays in place.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(out_res)))
    else $error("stalled result changed");

endmodule

`default_nettype wire

// ===== test/tb_byte_stuffing_deframer.sv =====
`timescale 1ns / 1ps

module tb_byte_stuffing_deframer;
  import bsd_pkg::*;

  localparam int STUCK_LIMIT = 2000;
  localparam int RANDOM_ITEMS = 340;

  // Ways in which a random frame may be spoilt.
  typedef enum int {
    FLAW_NONE,
    FLAW_BAD_CODE,
    FLAW_ESC_AT_END,
    FLAW_RESTART,
    FLAW_NO_END
  } flaw_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [7:0]       in_byte = 8'h00;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [7:0]       out_byte;
  logic             frame_end;
  logic [LEN_W-1:0] frame_len;
  logic             bad_escape;
  logic             overflowed;

  byte_stuffing_deframer u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_byte    (in_byte),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_byte   (out_byte),
    .frame_end  (frame_end),
    .frame_len  (frame_len),
    .bad_escape (bad_escape),
    .overflowed (overflowed)
  );

  always #2 clk = ~clk;

  // Decoder state as the testbench expects it to be.
  logic             dec_in_frame = 1'b0;
  logic             dec_esc_pending = 1'b0;
  logic [LEN_W-1:0] dec_count = '0;
  logic             dec_bad_seen = 1'b0;
  logic             dec_over_seen = 1'b0;

  res_t decoded_results_due[$];

  int items_sent = 0;
  int burst_left = 0;
  int mismatches = 0;
  int data_seen = 0;
  int ends_seen = 0;
  int ends_bad = 0;
  int ends_over = 0;
  int stuck_cycles = 0;
  int rx_left = 0;

  // Works out the result, if any, that one accepted byte causes.
  task automatic decode_serial_byte(input logic [7:0] b);
    logic [7:0] decoded;
    logic       has_byte;
    has_byte = 1'b0;
    decoded = 8'h00;
    if (b == SYM_START) begin
      dec_in_frame = 1'b1;
      dec_esc_pending = 1'b0;
      dec_count = '0;
      dec_bad_seen = 1'b0;
      dec_over_seen = 1'b0;
    end else if (dec_in_frame) begin
      if (b == SYM_END) begin
        if (dec_esc_pending) dec_bad_seen = 1'b1;
        decoded_results_due.push_back('{data: 8'h00, frame_end: 1'b1, len: dec_count,
                                        bad_escape: dec_bad_seen,
                                        overflowed: dec_over_seen});
        dec_in_frame = 1'b0;
        dec_esc_pending = 1'b0;
      end else if (dec_esc_pending) begin
        dec_esc_pending = 1'b0;
        has_byte = 1'b1;
        case (b)
          ESC_CODE_START: decoded = SYM_START;
          ESC_CODE_END:   decoded = SYM_END;
          ESC_CODE_ESC:   decoded = SYM_ESC;
          ESC_CODE_FOUR:  decoded = ESC_BYTE_FOUR;
          default: begin
            has_byte = 1'b0;
            dec_bad_seen = 1'b1;
          end
        endcase
      end else if (b == SYM_ESC) begin
        dec_esc_pending = 1'b1;
      end else begin
        has_byte = 1'b1;
        decoded = b;
      end
    end
    // A decoded byte past the frame limit is dropped and flagged.
    if (has_byte) begin
      if (dec_count >= MAX_FRAME) begin
        dec_over_seen = 1'b1;
      end else begin
        dec_count = dec_count + 1'b1;
        decoded_results_due.push_back('{data: decoded, frame_end: 1'b0, len: dec_count,
                                        bad_escape: dec_bad_seen,
                                        overflowed: dec_over_seen});
      end
    end
  endtask

  // Sends one byte, with bursts and random gaps, and predicts on the transfer.
  task automatic send_byte(input logic [7:0] b);
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 24);
      if ($urandom_range(0, 3) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_byte <= b;
    do @(posedge clk); while (in_stall);
    decode_serial_byte(b);
    items_sent++;
  endtask

  // Sends one decoded byte, escaping it where the framing needs it.
  task automatic send_encoded(input logic [7:0] d);
    if (d == SYM_START) begin
      send_byte(SYM_ESC);
      send_byte(ESC_CODE_START);
    end else if (d == SYM_END) begin
      send_byte(SYM_ESC);
      send_byte(ESC_CODE_END);
    end else if (d == SYM_ESC) begin
      send_byte(SYM_ESC);
      send_byte(ESC_CODE_ESC);
    end else if (d == ESC_BYTE_FOUR && $urandom_range(0, 1) == 1) begin
      send_byte(SYM_ESC);
      send_byte(ESC_CODE_FOUR);
    end else begin
      send_byte(d);
    end
  endtask

  // Random payload, weighted towards the bytes that need escaping.
  task automatic send_payload(input int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 3) == 0) send_encoded(8'($urandom_range(0, 5)));
      else send_encoded(8'($urandom_range(0, 255)));
    end
  endtask

  // Holds the sender off until every expected result has arrived.
  task automatic wait_results_drained();
    in_valid <= 1'b0;
    burst_left = 0;
    while (decoded_results_due.size() != 0) @(posedge clk);
  endtask

  // Symbols outside a frame, every escape code, and the awkward corners.
  task automatic test_directed_cases();
    logic [7:0] seq[$];
    seq = '{8'h55, SYM_END, SYM_ESC,
            SYM_START, 8'hFF, 8'h03, 8'h80,
            SYM_ESC, ESC_CODE_START, SYM_ESC, ESC_CODE_END,
            SYM_ESC, ESC_CODE_ESC, SYM_ESC, ESC_CODE_FOUR, SYM_END,
            SYM_START, SYM_ESC, SYM_START, SYM_ESC, SYM_ESC,
            ESC_BYTE_FOUR, SYM_ESC, SYM_END};
    foreach (seq[i]) send_byte(seq[i]);
    wait_results_drained();
  endtask

  // One frame that fills up to the limit and then runs past it.
  task automatic test_frame_limit();
    send_byte(SYM_START);
    send_payload(MAX_FRAME);
    send_payload(4);
    send_encoded(SYM_ESC);
    send_byte(SYM_ESC);
    send_byte(8'h35);
    send_byte(SYM_END);
    wait_results_drained();
  endtask

  // Mostly well-formed frames with random content, plus noise and spoilt frames.
  task automatic test_random_traffic(input int count);
    int    first_item;
    int    frames;
    int    len;
    flaw_t flaw;
    first_item = items_sent;
    frames = 0;
    while (items_sent - first_item < count) begin
      if ($urandom_range(0, 99) < 8) begin
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
      end else begin
        flaw = ($urandom_range(0, 99) < 20) ? flaw_t'($urandom_range(1, 4)) : FLAW_NONE;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 12);
        send_byte(SYM_START);
        send_payload(len / 2);
        case (flaw)
          FLAW_BAD_CODE: begin
            send_byte(SYM_ESC);
            send_byte(8'($urandom_range(0, 255)));
          end
          FLAW_RESTART: begin
            if ($urandom_range(0, 1) == 1) send_byte(SYM_ESC);
            send_byte(SYM_START);
          end
          default: ;
        endcase
        send_payload(len - len / 2);
        if (flaw == FLAW_ESC_AT_END) send_byte(SYM_ESC);
        if (flaw != FLAW_NO_END) send_byte(SYM_END);
      end
      frames++;
      if (frames % 40 == 0) wait_results_drained();
    end
  endtask

  // Receiver stall pattern: short stalls, short runs, and now and then a long free run.
  always @(posedge clk) begin
    if (rx_left != 0) begin
      rx_left <= rx_left - 1;
    end else if (out_stall) begin
      out_stall <= 1'b0;
      rx_left <= ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80) : $urandom_range(0, 10);
    end else begin
      out_stall <= 1'b1;
      rx_left <= $urandom_range(0, 4);
    end
  end

  // Each result transfer is compared with the oldest expectation.
  always @(posedge clk) begin
    res_t got;
    res_t want;
    if (!rst && out_valid && !out_stall) begin
      got = '{data: out_byte, frame_end: frame_end, len: frame_len,
              bad_escape: bad_escape, overflowed: overflowed};
      if (decoded_results_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected result: byte %02h end %0b len %0d bad %0b ovf %0b",
                   got.data, got.frame_end, got.len, got.bad_escape, got.overflowed);
      end else begin
        want = decoded_results_due.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"Mismatch: expected byte %02h end %0b len %0d bad %0b ovf %0b, ",
                      "got byte %02h end %0b len %0d bad %0b ovf %0b"},
                     want.data, want.frame_end, want.len, want.bad_escape,
                     want.overflowed, got.data, got.frame_end,
                     got.len, got.bad_escape, got.overflowed);
        end
        if (want.frame_end) begin
          ends_seen++;
          if (want.bad_escape) ends_bad++;
          if (want.overflowed) ends_over++;
        end else begin
          data_seen++;
        end
      end
    end
  end

  // Counts cycles in which no transfer happens on either side.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) stuck_cycles <= 0;
    else stuck_cycles <= stuck_cycles + 1;
  end

  initial begin
    wait (stuck_cycles >= STUCK_LIMIT);
    $display("Timed out with %0d results outstanding", decoded_results_due.size());
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_cases();
    test_frame_limit();
    test_random_traffic(RANDOM_ITEMS);
    wait_results_drained();
    repeat (8) @(posedge clk);
    $display("Sent %0d bytes; checked %0d data bytes and %0d frame ends.",
             items_sent, data_seen, ends_seen);
    $display("Frame ends with a bad escape: %0d, with overflow: %0d; mismatches: %0d.",
             ends_bad, ends_over, mismatches);
    if (mismatches == 0 && decoded_results_due.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
